[design/stereo_feedback_delay_assert.svh]
// Assertion macros for the stereo feedback delay block.
// Depends on nothing; included by the top level only.
`ifndef STEREO_FEEDBACK_DELAY_ASSERT_SVH
`define STEREO_FEEDBACK_DELAY_ASSERT_SVH

// Same-cycle implication, held off during reset
`define SFD_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, held off during reset
`define SFD_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sfd_pkg.sv]
// Shared types and constants for the stereo feedback delay.
// No dependencies; used by every module of the block except sfd_ram.
`default_nettype none

package sfd_pkg;

    // Default sizes
    localparam int DEF_STORE_DEPTH = 131072;
    localparam int DEF_SAMPLE_BITS = 16;

    // Configuration register widths
    localparam int DLY_W      = 17;
    localparam int FB_W       = 16;
    localparam int MIX_W      = 17;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 2;

    // Q1.16 unity
    localparam logic [MIX_W-1:0] UNITY_Q16 = 17'd65536;

    // Reset values of the registers
    localparam logic [DLY_W-1:0] DLY_RESET = 17'd16800;
    localparam logic [FB_W-1:0]  FB_RESET  = 16'd29491;
    localparam logic [MIX_W-1:0] WET_RESET = 17'd16384;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_WET_MIX  = 2'd2
    } t_cfg_reg;

    // Gains handed to each lane
    typedef struct packed {
        logic [MIX_W-1:0] wet;
        logic [MIX_W-1:0] dry;
        logic [FB_W-1:0]  fb;
    } t_gains;

    // Per-beat control from the address stage to the lanes
    typedef struct packed {
        logic adv;     // item in the multiply stage moves on this cycle
        logic fwd;     // delayed sample comes from the previous frame's write-back
        logic filled;  // read slot has been written since reset
    } t_lane_ctl;

endpackage

`default_nettype wire

[design/sfd_ram.sv]
// Generic single-write, single-read RAM with registered read (read-old on collision).
// No dependencies.
`default_nettype none

module sfd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[design/sfd_dly_mod.sv]
// Delay length reduction modulo the store depth: reciprocal estimate of the quotient,
// then one compare and subtract. Depends on sfd_pkg.
`default_nettype none

module sfd_dly_mod #(
    parameter int STORE_DEPTH = sfd_pkg::DEF_STORE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_load,
    input  wire logic [sfd_pkg::DLY_W-1:0]      i_value,
    output logic      [$clog2(STORE_DEPTH):0]   o_dmod,
    output logic                                o_busy
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int AW1    = ADDR_W + 1;
    localparam int DLY_W  = sfd_pkg::DLY_W;
    localparam int RCP_W  = DLY_W + 1;
    localparam int PRD_W  = DLY_W + RCP_W;
    localparam int QD_W   = RCP_W + AW1;
    localparam int CMP_W  = ((AW1 > DLY_W) ? AW1 : DLY_W) + 1;
    // floor(2^DLY_W / depth): the quotient estimate is exact or one low
    localparam logic [RCP_W-1:0] RECIP     = RCP_W'((1 << DLY_W) / STORE_DEPTH);
    localparam logic [AW1-1:0]   DEPTH_X   = AW1'(STORE_DEPTH);
    localparam logic [DLY_W-1:0] REM_RESET = DLY_W'(int'(sfd_pkg::DLY_RESET) % STORE_DEPTH);

    logic [DLY_W-1:0] r_val, n_val;
    logic [RCP_W-1:0] r_q, n_q;
    logic [DLY_W-1:0] r_rem, n_rem;
    logic             r_est, n_est;   // quotient estimate pending
    logic             r_fix, n_fix;   // remainder correction pending
    logic [PRD_W-1:0] prod;
    logic [QD_W-1:0]  qd;
    logic [DLY_W-1:0] rem_est;

    // quotient estimate by constant multiply, remainder before correction
    assign prod    = PRD_W'(r_val) * PRD_W'(RECIP);
    assign qd      = QD_W'(r_q) * QD_W'(DEPTH_X);
    assign rem_est = r_val - qd[DLY_W-1:0];

    // two-step reduction, restarted by every load
    always_comb begin
        n_val = r_val;
        n_q   = r_q;
        n_rem = r_rem;
        n_est = 1'b0;
        n_fix = r_est;
        if (r_est) begin
            n_q = prod[PRD_W-1:DLY_W];
        end
        if (r_fix) begin
            if (CMP_W'(rem_est) >= CMP_W'(DEPTH_X)) begin
                n_rem = rem_est - DLY_W'(DEPTH_X);
            end else begin
                n_rem = rem_est;
            end
        end
        if (i_load) begin
            n_val = i_value;
            n_est = 1'b1;
            n_fix = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= sfd_pkg::DLY_RESET;
            r_q   <= '0;
            r_rem <= REM_RESET;
            r_est <= 1'b0;
            r_fix <= 1'b0;
        end else begin
            r_val <= n_val;
            r_q   <= n_q;
            r_rem <= n_rem;
            r_est <= n_est;
            r_fix <= n_fix;
        end
    end

    assign o_dmod = AW1'(r_rem);
    assign o_busy = r_est || r_fix;

endmodule

`default_nettype wire

[design/sfd_lane.sv]
// One channel lane: feedback write-back and dry/wet mix for one sample per beat.
// Depends on sfd_pkg.
`default_nettype none

module sfd_lane #(
    parameter int SAMPLE_BITS = sfd_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                          i_clk,
    input  wire sfd_pkg::t_lane_ctl            i_ctl,
    input  wire sfd_pkg::t_gains               i_gains,
    input  wire logic signed [SAMPLE_BITS-1:0] i_in,
    input  wire logic signed [SAMPLE_BITS-1:0] i_rdata,
    output logic signed      [SAMPLE_BITS-1:0] o_back,
    output logic signed      [SAMPLE_BITS-1:0] o_out
);

    localparam int S    = SAMPLE_BITS;
    localparam int SW   = S + 3;       // saturation input width
    localparam int FBPW = S + 17;      // sample x feedback product
    localparam int MPW  = S + 18;      // sample x mix product
    localparam int MSW  = S + 19;      // mix sum
    localparam logic signed [SW-1:0]   MAXV = {{(SW-S+1){1'b0}}, {(S-1){1'b1}}};
    localparam logic signed [SW-1:0]   MINV = {{(SW-S+1){1'b1}}, {(S-1){1'b0}}};
    localparam logic signed [FBPW-1:0] FB_HALF  = FBPW'(32768);
    localparam logic signed [MSW-1:0]  MIX_HALF = MSW'(32768);

    function automatic logic signed [S-1:0] sat_s(input logic signed [SW-1:0] v);
        logic signed [S-1:0] res;
        if (v > MAXV) begin
            res = MAXV[S-1:0];
        end else if (v < MINV) begin
            res = MINV[S-1:0];
        end else begin
            res = v[S-1:0];
        end
        return res;
    endfunction

    logic signed [S-1:0]    r_back;
    logic signed [S-1:0]    dly;
    logic signed [FBPW-1:0] p_fb;
    logic signed [FBPW-1:0] fb_rnd;
    logic signed [S:0]      fb_q;
    logic signed [SW-1:0]   back_sum;
    logic signed [MPW-1:0]  p_dry, p_wet;
    logic signed [MPW-1:0]  r_p_dry, r_p_wet;
    logic signed [MSW-1:0]  mix_rnd;

    // delayed sample: forward last write-back, else store, else zero if never written
    always_comb begin
        if (i_ctl.fwd) begin
            dly = r_back;
        end else if (i_ctl.filled) begin
            dly = i_rdata;
        end else begin
            dly = '0;
        end
    end

    // write-back value: in + round(d * fb), saturated
    assign p_fb     = dly * $signed({1'b0, i_gains.fb});
    assign fb_rnd   = p_fb + FB_HALF;
    assign fb_q     = fb_rnd[FBPW-1:16];
    assign back_sum = SW'(i_in) + SW'(fb_q);
    assign o_back   = sat_s(back_sum);

    // mix products
    assign p_dry = i_in * $signed({1'b0, i_gains.dry});
    assign p_wet = dly  * $signed({1'b0, i_gains.wet});

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_back  <= o_back;
            r_p_dry <= p_dry;
            r_p_wet <= p_wet;
        end
    end

    // output stage: round and saturate the mix
    assign mix_rnd = MSW'(r_p_dry) + MSW'(r_p_wet) + MIX_HALF;
    assign o_out   = sat_s(mix_rnd[MSW-1:16]);

endmodule

`default_nettype wire

[design/stereo_feedback_delay.sv]
// Stereo feedback delay: each input beat passes the address, multiply and output stages.
// Throughput one frame per cycle unless the output stalls, bounded by the single read
// and write port of the store. After each delay write the input is held off while
// the delay is reduced modulo the depth; no hold-off after reset.
// The store needs no clearing pass: the write position and a wrap flag read unwritten slots as zero.
// Reset is synchronous, active low; registers return to their documented values.
`default_nettype none

`include "stereo_feedback_delay_assert.svh"

module stereo_feedback_delay #(
    parameter int STORE_DEPTH = sfd_pkg::DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = sfd_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // input frames
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [left_in, right_in] from bit 0, zero pad to bytes
    input  wire logic [((2*SAMPLE_BITS+7)/8)*8-1:0]  i_s_axis_tdata,
    // output frames
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [left_out, right_out] from bit 0, zero pad to bytes
    output logic      [((2*SAMPLE_BITS+7)/8)*8-1:0]  o_m_axis_tdata,
    // configuration writes
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [sfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [sfd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int S       = SAMPLE_BITS;
    localparam int TDATA_W = ((2*S+7)/8)*8;
    localparam int ADDR_W  = $clog2(STORE_DEPTH);
    localparam int AW1     = ADDR_W + 1;
    localparam logic [AW1-1:0]    DEPTH_X = AW1'(STORE_DEPTH);
    localparam logic [ADDR_W-1:0] WR_LAST = ADDR_W'(STORE_DEPTH - 1);

    // configuration
    logic                            cfg_we;
    logic                            dly_load;
    logic [AW1-1:0]                  dmod;
    logic                            dly_busy;
    logic [sfd_pkg::FB_W-1:0]        r_fb;
    logic [sfd_pkg::MIX_W-1:0]       r_wet, r_dry, wet_clamp;
    sfd_pkg::t_gains                 gains;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign wet_clamp   = i_cfg_data[16] ? sfd_pkg::UNITY_Q16 : i_cfg_data;
    assign dly_load    = cfg_we && (sfd_pkg::t_cfg_reg'(i_cfg_index) == sfd_pkg::REG_DELAY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb  <= sfd_pkg::FB_RESET;
            r_wet <= sfd_pkg::WET_RESET;
            r_dry <= sfd_pkg::UNITY_Q16 - sfd_pkg::WET_RESET;
        end else if (cfg_we) begin
            case (sfd_pkg::t_cfg_reg'(i_cfg_index))
                sfd_pkg::REG_FEEDBACK: begin
                    r_fb <= i_cfg_data[sfd_pkg::FB_W-1:0];
                end
                sfd_pkg::REG_WET_MIX: begin
                    r_wet <= wet_clamp;
                    r_dry <= sfd_pkg::UNITY_Q16 - wet_clamp;
                end
                default: begin
                end
            endcase
        end
    end

    assign gains = '{wet: r_wet, dry: r_dry, fb: r_fb};

    sfd_dly_mod #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_dly_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (dly_load),
        .i_value (i_cfg_data[sfd_pkg::DLY_W-1:0]),
        .o_dmod  (dmod),
        .o_busy  (dly_busy)
    );

    // pipeline control
    logic en, acc;
    logic r_b_valid, r_c_valid;

    assign en              = !r_c_valid || i_m_axis_tready;
    assign o_s_axis_tready = en && !dly_busy;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    // address stage: write position, read position, fill check
    logic [ADDR_W-1:0] r_wr, n_wr;
    logic              r_wrapped, n_wrapped;
    logic [AW1-1:0]    rd_sum;
    logic [ADDR_W-1:0] rd;
    logic              filled, fwd;
    logic [ADDR_W-1:0] r_b_wr;
    logic              r_b_fwd, r_b_filled;
    logic signed [S-1:0] r_b_left, r_b_right;

    always_comb begin
        rd_sum = {1'b0, r_wr} + DEPTH_X - dmod;
        if (rd_sum >= DEPTH_X) begin
            rd_sum = rd_sum - DEPTH_X;
        end
        rd     = rd_sum[ADDR_W-1:0];
        filled = r_wrapped || (rd < r_wr);
        fwd    = r_b_valid && (rd == r_b_wr);
        n_wr      = r_wr;
        n_wrapped = r_wrapped;
        if (acc) begin
            if (r_wr == WR_LAST) begin
                n_wr      = '0;
                n_wrapped = 1'b1;
            end else begin
                n_wr = r_wr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr      <= '0;
            r_wrapped <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_wr      <= n_wr;
            r_wrapped <= n_wrapped;
            if (en) begin
                r_b_valid <= acc;
                r_c_valid <= r_b_valid;
            end
        end
    end

    // beat payload into the multiply stage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_b_wr     <= r_wr;
            r_b_fwd    <= fwd;
            r_b_filled <= filled;
            r_b_left   <= i_s_axis_tdata[S-1:0];
            r_b_right  <= i_s_axis_tdata[2*S-1:S];
        end
    end

    // echo store, both channels in one word
    logic [2*S-1:0]       ram_q;
    logic signed [S-1:0]  back_l, back_r, out_l, out_r;
    logic                 ram_we;
    sfd_pkg::t_lane_ctl   lane_ctl;

    assign ram_we   = en && r_b_valid;
    assign lane_ctl = '{adv: ram_we, fwd: r_b_fwd, filled: r_b_filled};

    sfd_ram #(
        .WIDTH (2*S),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_wr),
        .i_wdata ({back_r, back_l}),
        .i_re    (acc),
        .i_raddr (rd),
        .o_rdata (ram_q)
    );

    // two lanes, one per channel
    sfd_lane #(
        .SAMPLE_BITS (S)
    ) u_lane_l (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_gains (gains),
        .i_in    (r_b_left),
        .i_rdata (ram_q[S-1:0]),
        .o_back  (back_l),
        .o_out   (out_l)
    );

    sfd_lane #(
        .SAMPLE_BITS (S)
    ) u_lane_r (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_gains (gains),
        .i_in    (r_b_right),
        .i_rdata (ram_q[2*S-1:S]),
        .o_back  (back_r),
        .o_out   (out_r)
    );

    // merge lanes into the output beat
    assign o_m_axis_tvalid = r_c_valid;
    assign o_m_axis_tdata  = TDATA_W'({out_r, out_l});

    // checks
    `SFD_ASSERT_IMP(a_busy_blocks_input, i_clk, i_rst_n, dly_busy, !o_s_axis_tready,
        "input accepted while delay reduction busy")
    `SFD_ASSERT_NXT(a_wr_step, i_clk, i_rst_n, acc && (r_wr != WR_LAST),
        (r_wr == $past(r_wr) + 1'b1), "write position did not advance by one")
    `SFD_ASSERT_NXT(a_wr_wrap, i_clk, i_rst_n, acc && (r_wr == WR_LAST),
        (r_wr == '0) && r_wrapped, "write position did not wrap")
    `SFD_ASSERT_NXT(a_wrapped_sticky, i_clk, i_rst_n, r_wrapped, r_wrapped,
        "fill flag cleared without reset")

endmodule

`default_nettype wire

[sim/tb_stereo_feedback_delay.sv]
// Self-checking testbench for the stereo feedback delay block.
// Depends on sfd_pkg and the stereo_feedback_delay top level; carries its own echo predictor.
`timescale 1ns / 100ps

module tb_stereo_feedback_delay;

    localparam int STORE_DEPTH = sfd_pkg::DEF_STORE_DEPTH;
    localparam int SB          = sfd_pkg::DEF_SAMPLE_BITS;
    localparam int CFG_IDX_W   = sfd_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = sfd_pkg::CFG_DATA_W;
    localparam int DLY_W       = sfd_pkg::DLY_W;
    localparam int FB_W        = sfd_pkg::FB_W;
    localparam int MIX_W       = sfd_pkg::MIX_W;
    localparam int DATA_W      = ((2*SB+7)/8)*8;
    localparam longint SMAX    = (longint'(1) << (SB-1)) - 1;
    localparam longint SMIN    = -SMAX - 1;
    localparam longint UNITY   = longint'(sfd_pkg::UNITY_Q16);

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef logic signed [SB-1:0] t_sample;

    typedef struct {
        t_sample left;
        t_sample right;
    } t_stereo;

    // DUT ports
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_s_axis_tvalid = 1'b0;
    logic              o_s_axis_tready;
    logic [DATA_W-1:0] i_s_axis_tdata  = '0;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [DATA_W-1:0] o_m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // predictor state: echo store, write position and registers
    bit signed [SB-1:0] left_echo  [STORE_DEPTH];
    bit signed [SB-1:0] right_echo [STORE_DEPTH];
    int unsigned        write_pos  = 0;
    logic [DLY_W-1:0]   delay_len  = sfd_pkg::DLY_RESET;
    logic [FB_W-1:0]    fb_gain    = sfd_pkg::FB_RESET;
    logic [MIX_W-1:0]   wet_mix    = sfd_pkg::WET_RESET;

    t_stereo mixed_q[$];

    int  err_count  = 0;
    int  frames_in  = 0;
    int  frames_out = 0;
    int  cfg_writes = 0;
    int  stall_left = 0;
    bit  quiet      = 1'b0;   // no gaps and no stalls while set

    stereo_feedback_delay i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------

    function automatic t_sample clamp_sample(longint v);
        if (v > SMAX) return t_sample'(SMAX);
        if (v < SMIN) return t_sample'(SMIN);
        return v[SB-1:0];
    endfunction

    // divide by 2^16, halves toward plus infinity
    function automatic longint round_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic t_sample mix_sample(longint dry, longint dly);
        longint m;
        m = (longint'(wet_mix) > UNITY) ? UNITY : longint'(wet_mix);
        return clamp_sample(round_q16(dry * (UNITY - m) + dly * m));
    endfunction

    function automatic t_sample feedback_sample(longint dry, longint dly);
        return clamp_sample(dry + round_q16(dly * longint'(fb_gain)));
    endfunction

    // read before write, both channels share one position
    task automatic predict_frame(t_sample l, t_sample r);
        int unsigned wr, rd, d;
        longint      dl, dr;
        t_stereo     res;
        wr = write_pos;
        d  = delay_len % STORE_DEPTH;
        rd = (wr + STORE_DEPTH - d) % STORE_DEPTH;
        dl = left_echo[rd];
        dr = right_echo[rd];
        res.left  = mix_sample(l, dl);
        res.right = mix_sample(r, dr);
        left_echo[wr]  = feedback_sample(l, dl);
        right_echo[wr] = feedback_sample(r, dr);
        write_pos = (wr + 1) % STORE_DEPTH;
        mixed_q = {mixed_q, res};
    endtask

    task automatic apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        case (idx)
            sfd_pkg::REG_DELAY:    delay_len = data[DLY_W-1:0];
            sfd_pkg::REG_FEEDBACK: fb_gain   = data[FB_W-1:0];
            sfd_pkg::REG_WET_MIX:  wet_mix   = data[MIX_W-1:0];
            default: ;   // unmapped index, no effect
        endcase
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(string msg);
        err_count++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic check_beat(logic [DATA_W-1:0] beat);
        t_stereo want;
        t_sample got_l, got_r;
        got_l = beat[SB-1:0];
        got_r = beat[2*SB-1:SB];
        frames_out++;
        if (mixed_q.size() == 0) begin
            report_mismatch($sformatf("output beat %0d with no frame pending", frames_out));
        end else begin
            want = mixed_q.pop_front();
            if (got_l !== want.left)
                report_mismatch($sformatf("beat %0d left_out %0d, expected %0d",
                                          frames_out, got_l, want.left));
            if (got_r !== want.right)
                report_mismatch($sformatf("beat %0d right_out %0d, expected %0d",
                                          frames_out, got_r, want.right));
        end
    endtask

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // output side: random back-pressure and result check
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            stall_left = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready)
                check_beat(o_m_axis_tdata);
            if (quiet) begin
                stall_left = 0;
                i_m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 99) < 70) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                stall_left = pick_gap();
                i_m_axis_tready <= 1'b0;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_frame(t_sample l, t_sample r);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {r, l};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_frame(l, r);
        frames_in++;
    endtask

    // stop sending and wait for every pending beat
    task automatic drain_frames();
        i_s_axis_tvalid <= 1'b0;
        while (mixed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        cfg_writes++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_echo(logic [CFG_DATA_W-1:0] dly, logic [CFG_DATA_W-1:0] fb,
                            logic [CFG_DATA_W-1:0] wet);
        drain_frames();
        cfg_write(sfd_pkg::REG_DELAY, dly);
        cfg_write(sfd_pkg::REG_FEEDBACK, fb);
        cfg_write(sfd_pkg::REG_WET_MIX, wet);
    endtask

    function automatic t_sample rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return t_sample'(SMAX);
        if (r == 1) return t_sample'(SMIN);
        if (r == 2) return t_sample'($urandom_range(0, 200) - 100);
        return t_sample'($urandom);
    endfunction

    // ---------------- tests ----------------

    // registers at reset, long delay so only zeros come back
    task automatic test_reset_values();
        send_frame(t_sample'(SMAX), t_sample'(SMIN));
        send_frame(t_sample'(SMIN), t_sample'(SMAX));
        send_frame('0, t_sample'(1));
        send_frame(t_sample'(-1), '0);
    endtask

    // one-frame echo, all wet, strong feedback: store saturates
    task automatic test_short_echo();
        set_echo(17'd1, 17'd64880, 17'd65536);
        repeat (4) send_frame(t_sample'(SMAX), t_sample'(SMIN));
        repeat (2) send_frame(t_sample'(SMIN), t_sample'(SMAX));
        repeat (2) send_frame('0, '0);
    endtask

    // wet above one is clamped, feedback bit 16 dropped
    task automatic test_wet_above_unity();
        set_echo(17'd2, 17'h1FFFF, 17'h1FFFF);
        send_frame(t_sample'(SMAX), t_sample'(-12345));
        send_frame(t_sample'(SMIN), t_sample'(12345));
        send_frame(t_sample'(1), t_sample'(-1));
        send_frame(t_sample'(100), t_sample'(-100));
    endtask

    // no wet share and no feedback: input passes straight through
    task automatic test_dry_only();
        set_echo(17'd3, 17'd0, 17'd0);
        send_frame(t_sample'(SMAX), t_sample'(SMIN));
        send_frame(t_sample'(-7), t_sample'(7));
        send_frame(t_sample'(SMIN), t_sample'(SMAX));
    endtask

    // write to an unmapped index leaves all registers as they were
    task automatic test_unknown_index();
        set_echo(17'd1, 17'd32768, 17'd32768);
        cfg_write(REG_UNUSED, 17'h1FFFF);
        cfg_write(REG_UNUSED, 17'd0);
        send_frame(t_sample'(20000), t_sample'(-20000));
        send_frame(t_sample'(-3), t_sample'(3));
        send_frame(t_sample'(SMAX), t_sample'(SMAX));
    endtask

    // largest delay and zero delay, which reads the slot about to be written
    task automatic test_delay_extremes();
        set_echo(17'd131071, 17'd40000, 17'd50000);
        send_frame(t_sample'(SMAX), t_sample'(SMIN));
        send_frame(t_sample'(1234), t_sample'(-1234));
        set_echo(17'd0, 17'd40000, 17'd50000);
        send_frame(t_sample'(SMIN), t_sample'(SMAX));
        send_frame(t_sample'(-5), t_sample'(5));
    endtask

    // random settings per phase, random frames, random idling
    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] dly, fb, wet;
        int r;
        for (int ph = 0; ph < 10; ph++) begin
            r = $urandom_range(0, 99);
            if (r < 60)      dly = CFG_DATA_W'($urandom_range(1, 48));
            else if (r < 68) dly = 17'd0;
            else if (r < 76) dly = 17'd131071;
            else if (r < 90) dly = CFG_DATA_W'($urandom_range(49, 4000));
            else             dly = CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
            r = $urandom_range(0, 9);
            if (r == 0)      fb = 17'd0;
            else if (r == 1) fb = 17'd64880;
            else if (r == 2) fb = 17'h1FFFF;
            else             fb = CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
            r = $urandom_range(0, 9);
            if (r == 0)      wet = 17'd0;
            else if (r == 1) wet = 17'd65536;
            else if (r == 2) wet = 17'h1FFFF;
            else if (r < 8)  wet = CFG_DATA_W'($urandom_range(0, 65536));
            else             wet = CFG_DATA_W'($urandom_range(0, 17'h1FFFF));
            set_echo(dly, fb, wet);
            if ($urandom_range(0, 4) == 0)
                cfg_write(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
            quiet = ($urandom_range(0, 3) == 0);
            repeat (200) send_frame(rand_sample(), rand_sample());
            quiet = 1'b0;
        end
    endtask

    // ---------------- sequence ----------------

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_short_echo();
        test_wet_above_unity();
        test_dry_only();
        test_unknown_index();
        test_delay_extremes();
        test_random_phases();

        drain_frames();
        repeat (10) @(posedge i_clk);
        if (mixed_q.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", mixed_q.size()));

        $display("Sent %0d frames, checked %0d beats, %0d register writes.",
                 frames_in, frames_out, cfg_writes);
        $display("Covered extreme gains and delays, wet clamp, unmapped index, unwritten slots.");
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // watchdog
    initial begin
        #36000000;
        $display("Timeout: run did not finish");
        $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/sfd_pkg.sv
design/sfd_ram.sv
design/sfd_dly_mod.sv
design/sfd_lane.sv
design/stereo_feedback_delay.sv
sim/tb_stereo_feedback_delay.sv
